// File: sv/srfq_pkg.sv
`timescale 1ns / 1ps
package srfq_pkg;

  localparam int LineLenDefault    = 64;
  localparam int QueueDepthDefault = 8;

  // action codes
  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_FETCH = 2'd1;
  localparam logic [1:0] ACT_RESET = 2'd2;

  localparam logic [7:0] CH_QUERY  = 8'h3F;
  localparam logic [7:0] CH_HOLD   = 8'h21;
  localparam logic [7:0] CH_START  = 8'h7E;
  localparam logic [7:0] CH_SRESET = 8'h18;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  localparam logic [1:0] QueryMax = 2'd2;

  typedef enum logic [3:0] {
    KIND_ABSORBED   = 4'd0,
    KIND_QUEUED     = 4'd1,
    KIND_DROPPED    = 4'd2,
    KIND_STATUS_VER = 4'd3,
    KIND_BANNER     = 4'd4,
    KIND_STATUS     = 4'd5,
    KIND_HOLD       = 4'd6,
    KIND_START      = 4'd7,
    KIND_SOFTRESET  = 4'd8,
    KIND_LINEBYTE   = 4'd9,
    KIND_EMPTY      = 4'd10,
    KIND_NOLINE     = 4'd11,
    KIND_RESET      = 4'd12
  } kind_e;

  typedef enum logic [2:0] {
    OP_EVENT,
    OP_CHAR,
    OP_TERM,
    OP_FETCH,
    OP_CLEAR
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_RD,
    ST_BYTE
  } state_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] line_byte;
    logic       system_command;
    logic       last;
    logic [3:0] lines_waiting;
  } out_t;

  typedef struct packed {
    op_e        op;
    kind_e      kind;
    logic [7:0] data;
  } cmd_t;

endpackage

// File: sv/srfq_ram.sv
`timescale 1ns / 1ps
module srfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/srfq_front.sv
`timescale 1ns / 1ps
module srfq_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  srfq_pkg::in_t  in_data,
  output logic           push_valid,
  input  logic           push_ready,
  output srfq_pkg::cmd_t push_cmd
);
  import srfq_pkg::*;

  logic [1:0] qcnt_r, qcnt_nxt;
  logic       accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  always_comb begin
    push_cmd.op   = OP_EVENT;
    push_cmd.kind = KIND_ABSORBED;
    push_cmd.data = in_data.data_byte;
    qcnt_nxt      = qcnt_r;
    unique case (in_data.action)
      ACT_BYTE: begin
        priority if (in_data.data_byte == CH_QUERY) begin
          priority if (qcnt_r == 2'd0) begin
            push_cmd.kind = KIND_STATUS_VER;
          end else if (qcnt_r == 2'd1) begin
            push_cmd.kind = KIND_BANNER;
          end else begin
            push_cmd.kind = KIND_STATUS;
          end
          if (accept && qcnt_r != QueryMax) begin
            qcnt_nxt = qcnt_r + 2'd1;
          end
        end else if (in_data.data_byte == CH_HOLD) begin
          push_cmd.kind = KIND_HOLD;
        end else if (in_data.data_byte == CH_START) begin
          push_cmd.kind = KIND_START;
        end else if (in_data.data_byte == CH_SRESET) begin
          push_cmd.kind = KIND_SOFTRESET;
        end else if (in_data.data_byte == CH_LF || in_data.data_byte == CH_CR) begin
          push_cmd.op = OP_TERM;
        end else begin
          push_cmd.op = OP_CHAR;
        end
      end
      ACT_FETCH: push_cmd.op = OP_FETCH;
      ACT_RESET: begin
        push_cmd.op = OP_CLEAR;
        if (accept) begin
          qcnt_nxt = 2'd0;
        end
      end
      default: push_cmd.op = OP_EVENT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r <= 2'd0;
    end else begin
      qcnt_r <= qcnt_nxt;
    end
  end

endmodule

// File: sv/srfq_cmd_fifo.sv
`timescale 1ns / 1ps
module srfq_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  srfq_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output srfq_pkg::cmd_t pop_cmd
);
  import srfq_pkg::*;

  cmd_t       entry_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_cmd    = entry_r[rptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
    end
  end

endmodule

// File: sv/srfq_back.sv
`timescale 1ns / 1ps
module srfq_back #(
  parameter int LINE_LEN    = srfq_pkg::LineLenDefault,
  parameter int QUEUE_DEPTH = srfq_pkg::QueueDepthDefault
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  srfq_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output srfq_pkg::out_t out_data
);
  import srfq_pkg::*;

  localparam int LB     = $clog2(LINE_LEN);
  localparam int NSLOT  = QUEUE_DEPTH + 1;   // one spare slot holds the partial line
  localparam int SW     = $clog2(NSLOT);
  localparam int CW     = $clog2(QUEUE_DEPTH + 1);
  localparam int LAW    = SW + LB;
  localparam int LDEPTH = NSLOT * (2 ** LB);
  localparam logic [LB-1:0] MaxChars  = LB'(LINE_LEN - 1);
  localparam logic [SW-1:0] LastSlot  = SW'(NSLOT - 1);
  localparam logic [CW-1:0] FullCount = CW'(QUEUE_DEPTH);

  state_e        state_r, state_nxt;
  logic [LB-1:0] plen_r, plen_nxt;
  logic [LB-1:0] tlen_r, tlen_nxt;
  logic          sys_r, sys_nxt;
  logic [SW-1:0] wslot_r, wslot_nxt;
  logic [SW-1:0] rslot_r, rslot_nxt;
  logic [SW-1:0] fslot_r, fslot_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [LB-1:0] flen_r, flen_nxt;
  logic          fsys_r, fsys_nxt;
  logic [LB-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_r, out_nxt;

  logic          out_free;
  logic          load;
  kind_e         kind;
  logic [7:0]    obyte;
  logic          osys;
  logic          olast;
  logic          is_last_byte;

  logic           line_we, line_re;
  logic [LAW-1:0] line_waddr, line_raddr;
  logic [7:0]     line_rdata;
  logic           len_we, len_re;
  logic [LB:0]    len_rdata;
  logic [LB-1:0]  len_trim;
  logic           len_sys;

  srfq_ram #(.WIDTH(8), .DEPTH(LDEPTH)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (cmd.data),
    .re    (line_re),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  // per slot: first-char-is-dollar flag and length with trailing blanks trimmed
  srfq_ram #(.WIDTH(LB + 1), .DEPTH(NSLOT)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (wslot_r),
    .wdata ({sys_r, tlen_r}),
    .re    (len_re),
    .raddr (rslot_r),
    .rdata (len_rdata)
  );

  assign len_trim     = len_rdata[LB-1:0];
  assign len_sys      = len_rdata[LB];
  assign out_free     = !out_valid_r || out_ready;
  assign is_last_byte = (LB'(idx_r + 1'b1) == flen_r);
  assign line_waddr   = {wslot_r, plen_r};
  assign line_raddr   = {fslot_r, idx_r};
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && out_free && cmd.op == OP_FETCH && count_r != '0) begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        if (len_trim != '0) begin
          state_nxt = ST_RD;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD: state_nxt = ST_BYTE;
      ST_BYTE: begin
        if (out_free) begin
          state_nxt = is_last_byte ? ST_IDLE : ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    plen_nxt  = plen_r;
    tlen_nxt  = tlen_r;
    sys_nxt   = sys_r;
    wslot_nxt = wslot_r;
    rslot_nxt = rslot_r;
    fslot_nxt = fslot_r;
    count_nxt = count_r;
    flen_nxt  = flen_r;
    fsys_nxt  = fsys_r;
    idx_nxt   = idx_r;
    cmd_ready = 1'b0;
    line_we   = 1'b0;
    line_re   = 1'b0;
    len_we    = 1'b0;
    len_re    = 1'b0;
    load      = 1'b0;
    kind      = KIND_ABSORBED;
    obyte     = 8'h00;
    osys      = 1'b0;
    olast     = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          load      = 1'b1;
          unique case (cmd.op)
            OP_EVENT: kind = cmd.kind;
            OP_CHAR: begin
              if (plen_r != MaxChars) begin
                line_we  = 1'b1;
                plen_nxt = plen_r + 1'b1;
                if (cmd.data != CH_SPACE && cmd.data != CH_TAB) begin
                  tlen_nxt = plen_r + 1'b1;
                end
                if (plen_r == '0) begin
                  sys_nxt = (cmd.data == CH_DOLLAR);
                end
              end
            end
            OP_TERM: begin
              if (plen_r != '0) begin
                plen_nxt = '0;
                tlen_nxt = '0;
                if (count_r == FullCount) begin
                  kind = KIND_DROPPED;
                end else begin
                  kind      = KIND_QUEUED;
                  len_we    = 1'b1;
                  wslot_nxt = (wslot_r == LastSlot) ? '0 : wslot_r + 1'b1;
                  count_nxt = count_r + 1'b1;
                end
              end
            end
            OP_FETCH: begin
              if (count_r == '0) begin
                kind = KIND_NOLINE;
              end else begin
                load      = 1'b0;
                len_re    = 1'b1;
                fslot_nxt = rslot_r;
                rslot_nxt = (rslot_r == LastSlot) ? '0 : rslot_r + 1'b1;
                count_nxt = count_r - 1'b1;
              end
            end
            OP_CLEAR: begin
              kind      = KIND_RESET;
              plen_nxt  = '0;
              tlen_nxt  = '0;
              wslot_nxt = '0;
              rslot_nxt = '0;
              count_nxt = '0;
            end
            default: kind = KIND_ABSORBED;
          endcase
        end
      end
      ST_LEN: begin
        if (len_trim == '0) begin
          if (out_free) begin
            load = 1'b1;
            kind = KIND_EMPTY;
          end
        end else begin
          flen_nxt = len_trim;
          fsys_nxt = len_sys;
          idx_nxt  = '0;
        end
      end
      ST_RD: line_re = 1'b1;
      ST_BYTE: begin
        if (out_free) begin
          load    = 1'b1;
          kind    = KIND_LINEBYTE;
          obyte   = line_rdata;
          osys    = fsys_r;
          olast   = is_last_byte;
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: load = 1'b0;
    endcase

    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    if (load) begin
      out_valid_nxt          = 1'b1;
      out_nxt.kind           = kind;
      out_nxt.line_byte      = obyte;
      out_nxt.system_command = osys;
      out_nxt.last           = olast;
      out_nxt.lines_waiting  = 4'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      plen_r      <= '0;
      tlen_r      <= '0;
      wslot_r     <= '0;
      rslot_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plen_r      <= plen_nxt;
      tlen_r      <= tlen_nxt;
      wslot_r     <= wslot_nxt;
      rslot_r     <= rslot_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sys_r   <= sys_nxt;
    fslot_r <= fslot_nxt;
    flen_r  <= flen_nxt;
    fsys_r  <= fsys_nxt;
    idx_r   <= idx_nxt;
    out_r   <= out_nxt;
  end

endmodule

// File: sv/serial_realtime_filter_line_queue_unit.sv
`timescale 1ns / 1ps
// Channel   Ports                                 Beat
// input     in_valid, in_ready, in_data           in_t: action, data_byte
// result    out_valid, out_ready, out_data        out_t: kind .. lines_waiting
//
// The back end handles a received byte, event or reset in its idle state; the front end and a
// two-entry command queue take a new beat every cycle while the queue is not full.
// A fetch first reads the length memory, then for each line byte does a registered read
// of the line memory and then loads the output register.
// rst_n is synchronous; no memory clearing pass is needed after reset.
// A stalled result holds the back end; the queue keeps accepting until full.
module serial_realtime_filter_line_queue_unit #(
  parameter int LINE_LEN    = srfq_pkg::LineLenDefault,
  parameter int QUEUE_DEPTH = srfq_pkg::QueueDepthDefault
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  srfq_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output srfq_pkg::out_t out_data
);
  import srfq_pkg::*;

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  srfq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  srfq_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  srfq_back #(
    .LINE_LEN    (LINE_LEN),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
